@@ rtl/lds_pkg.sv @@
// Shared types, register codes and helper functions for the LCD draw command sequencer.
`timescale 1ns / 1ps

package lds_pkg;

  localparam int PANEL_WIDTH_DEF  = 240;
  localparam int PANEL_HEIGHT_DEF = 320;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam logic [7:0] REG_ENTRY     = 8'h03;
  localparam logic [7:0] REG_GRAM_X    = 8'h20;
  localparam logic [7:0] REG_GRAM_Y    = 8'h21;
  localparam logic [7:0] REG_GRAM_DATA = 8'h22;
  localparam logic [7:0] REG_WIN_X0    = 8'h50;
  localparam logic [7:0] REG_WIN_X1    = 8'h51;
  localparam logic [7:0] REG_WIN_Y0    = 8'h52;
  localparam logic [7:0] REG_WIN_Y1    = 8'h53;

  localparam logic [15:0] EM_VERT = 16'b00001000;
  localparam logic [15:0] EM_INCH = 16'b00010000;
  localparam logic [15:0] EM_INCV = 16'b00100000;

  localparam logic [16:0] REPEAT_MAX = 17'h1FFFF;

  typedef enum logic [1:0] {
    OP_PIXEL = 2'd0,
    OP_LINE  = 2'd1,
    OP_RECT  = 2'd2,
    OP_FILL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } point_t;

  // one classified command, ready for the write sequencer
  typedef struct packed {
    op_t         op;
    logic [15:0] entry;
    logic [15:0] xmin;
    logic [15:0] xmax;
    logic [15:0] ymin;
    logic [15:0] ymax;
    logic [15:0] color;
    logic [16:0] repeat_count;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] entry_mode(rot_t rot, logic vert);
    logic [15:0] m;
    case (rot)
      ROT_0:   m = vert ? (EM_VERT | EM_INCH | EM_INCV) : (EM_INCH | EM_INCV);
      ROT_90:  m = vert ? EM_INCV : (EM_VERT | EM_INCV);
      ROT_180: m = vert ? EM_VERT : 16'h0000;
      ROT_270: m = vert ? EM_INCH : (EM_VERT | EM_INCH);
      default: m = 16'h0000;
    endcase
    return m;
  endfunction

  // screen to panel coordinates, 16-bit wrap
  function automatic point_t turn(rot_t rot, logic [15:0] x0, logic [15:0] y0,
                                  logic [15:0] w1, logic [15:0] h1);
    point_t p;
    case (rot)
      ROT_90:  begin p.x = w1 - y0; p.y = x0;      end
      ROT_180: begin p.x = w1 - x0; p.y = h1 - y0; end
      ROT_270: begin p.x = y0;      p.y = h1 - x0; end
      default: begin p.x = x0;      p.y = y0;      end
    endcase
    return p;
  endfunction

endpackage

@@ rtl/lds_front.sv @@
// Command intake: rotation register, coordinate turning, window ordering, repeat count.
`timescale 1ns / 1ps

module lds_front #(
  parameter int PANEL_WIDTH  = lds_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lds_pkg::PANEL_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [63:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  input  lds_pkg::q_status_t q_status,
  output logic              q_push,
  output lds_pkg::desc_t    q_data
);

  localparam logic [15:0] W1 = 16'(PANEL_WIDTH - 1);
  localparam logic [15:0] H1 = 16'(PANEL_HEIGHT - 1);
  localparam int FILL_FULL = PANEL_WIDTH * PANEL_HEIGHT;
  localparam logic [16:0] FILL_REP =
    (FILL_FULL > 131071) ? lds_pkg::REPEAT_MAX : 17'(FILL_FULL);

  lds_pkg::rot_t rotation;

  lds_pkg::op_t  op;
  logic [15:0]   sx, sy, len, rw, rh, color;
  logic          vert;
  logic [15:0]   fx, fy;
  lds_pkg::point_t pa, pb;
  logic [17:0]   area;
  logic [16:0]   area_sat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= lds_pkg::ROT_0;
    end else if (cfg_valid && cfg_ready) begin
      rotation <= lds_pkg::rot_t'(cfg_data);
    end
  end

  assign s_tready = !q_status.full;
  assign q_push   = s_tvalid && s_tready;

  always_comb begin
    op    = lds_pkg::op_t'(s_tuser);
    sx    = {7'd0, s_tdata[8:0]};
    sy    = {7'd0, s_tdata[17:9]};
    len   = {7'd0, s_tdata[26:18]};
    rw    = {7'd0, s_tdata[35:27]};
    rh    = {7'd0, s_tdata[44:36]};
    vert  = s_tdata[45];
    color = s_tdata[61:46];

    fx = sx + rw - 16'd1;
    fy = sy + rh - 16'd1;
    pa = lds_pkg::turn(rotation, sx, sy, W1, H1);
    pb = lds_pkg::turn(rotation, fx, fy, W1, H1);

    area     = rw[8:0] * rh[8:0];
    area_sat = (area > {1'b0, lds_pkg::REPEAT_MAX}) ? lds_pkg::REPEAT_MAX : area[16:0];

    q_data.op    = op;
    q_data.color = color;
    q_data.entry = lds_pkg::entry_mode(rotation, vert && (op == lds_pkg::OP_LINE));
    q_data.xmin  = pa.x;
    q_data.xmax  = pa.x;
    q_data.ymin  = pa.y;
    q_data.ymax  = pa.y;
    case (op)
      lds_pkg::OP_PIXEL: q_data.repeat_count = 17'd1;
      lds_pkg::OP_LINE:  q_data.repeat_count = {1'b0, len};
      lds_pkg::OP_RECT: begin
        q_data.repeat_count = area_sat;
        q_data.xmin = (pa.x > pb.x) ? pb.x : pa.x;
        q_data.xmax = (pa.x > pb.x) ? pa.x : pb.x;
        q_data.ymin = (pa.y > pb.y) ? pb.y : pa.y;
        q_data.ymax = (pa.y > pb.y) ? pa.y : pb.y;
      end
      lds_pkg::OP_FILL: begin
        q_data.repeat_count = FILL_REP;
        q_data.xmin = 16'd0;
        q_data.ymin = 16'd0;
      end
      default: q_data.repeat_count = 17'd1;
    endcase
  end

endmodule

@@ rtl/lds_queue.sv @@
// Small register queue of classified commands between intake and sequencer.
`timescale 1ns / 1ps

module lds_queue #(
  parameter int DEPTH = lds_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lds_pkg::desc_t     push_data,
  input  logic               pop,
  output lds_pkg::desc_t     pop_data,
  output lds_pkg::q_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  lds_pkg::desc_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign pop_data     = mem[rd_ptr];
  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);

endmodule

@@ rtl/lds_back.sv @@
// Write sequencer: steps through the register writes of the head command into an output register.
`timescale 1ns / 1ps

module lds_back #(
  parameter int PANEL_WIDTH  = lds_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lds_pkg::PANEL_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lds_pkg::q_status_t q_status,
  input  lds_pkg::desc_t     q_data,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [47:0]        m_tdata,
  output logic               m_tlast
);

  localparam logic [15:0] W1 = 16'(PANEL_WIDTH - 1);
  localparam logic [15:0] H1 = 16'(PANEL_HEIGHT - 1);

  typedef enum logic [3:0] {
    ST_ENTRY = 4'd0,
    ST_WX0   = 4'd1,
    ST_WX1   = 4'd2,
    ST_WY0   = 4'd3,
    ST_WY1   = 4'd4,
    ST_GX    = 4'd5,
    ST_GY    = 4'd6,
    ST_DATA  = 4'd7,
    ST_RX0   = 4'd8,
    ST_RX1   = 4'd9,
    ST_RY0   = 4'd10,
    ST_RY1   = 4'd11
  } step_t;

  step_t       step, cur, step_next;
  logic        busy;
  logic        load, emit, emit_last, is_rect;
  logic [7:0]  idx;
  logic [15:0] val;
  logic [16:0] rep;

  assign load    = !m_tvalid || m_tready;
  assign emit    = load && !q_status.empty;
  assign is_rect = (q_data.op == lds_pkg::OP_RECT);
  assign q_pop   = emit && emit_last;

  always_comb begin
    if (busy) begin
      cur = step;
    end else if (q_data.op == lds_pkg::OP_PIXEL) begin
      cur = ST_GX;
    end else begin
      cur = ST_ENTRY;
    end

    emit_last = is_rect ? (cur == ST_RY1) : (cur == ST_DATA);
    if (cur == ST_ENTRY && !is_rect) begin
      step_next = ST_GX;
    end else begin
      step_next = step_t'(cur + 4'd1);
    end

    rep = 17'd1;
    case (cur)
      ST_ENTRY: begin idx = lds_pkg::REG_ENTRY;     val = q_data.entry; end
      ST_WX0:   begin idx = lds_pkg::REG_WIN_X0;    val = q_data.xmin;  end
      ST_WX1:   begin idx = lds_pkg::REG_WIN_X1;    val = q_data.xmax;  end
      ST_WY0:   begin idx = lds_pkg::REG_WIN_Y0;    val = q_data.ymin;  end
      ST_WY1:   begin idx = lds_pkg::REG_WIN_Y1;    val = q_data.ymax;  end
      ST_GX:    begin idx = lds_pkg::REG_GRAM_X;    val = q_data.xmin;  end
      ST_GY:    begin idx = lds_pkg::REG_GRAM_Y;    val = q_data.ymin;  end
      ST_DATA: begin
        idx = lds_pkg::REG_GRAM_DATA;
        val = q_data.color;
        rep = q_data.repeat_count;
      end
      ST_RX0:   begin idx = lds_pkg::REG_WIN_X0;    val = 16'd0;        end
      ST_RX1:   begin idx = lds_pkg::REG_WIN_X1;    val = W1;           end
      ST_RY0:   begin idx = lds_pkg::REG_WIN_Y0;    val = 16'd0;        end
      ST_RY1:   begin idx = lds_pkg::REG_WIN_Y1;    val = H1;           end
      default:  begin idx = lds_pkg::REG_ENTRY;     val = 16'd0;        end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= ST_ENTRY;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= emit;
      end
      if (emit) begin
        busy <= !emit_last;
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {7'd0, rep, val, idx};
      m_tlast <= emit_last;
    end
  end

endmodule

@@ rtl/lcd_draw_command_sequencer.sv @@
// Top level of the LCD draw command sequencer: intake, command queue, write sequencer.
//
// channel  direction  handshake            payload
// s_*      in         s_tvalid/s_tready    s_tuser op; s_tdata coords, sizes, vertical, color
// cfg_*    in         cfg_valid/cfg_ready  cfg_data rotation
// m_*      out        m_tvalid/m_tready    m_tdata index, value, repeat; m_tlast
//
// Register writes per command: 3 for a pixel, 4 for a line or fill, 12 for a rectangle.
// A command is classified in its accept cycle and written into a QUEUE_DEPTH entry queue;
// the sequencer drains the head command one write per unstalled cycle into the output register.
// Commands keep being accepted while the queue has room, also while m_tready is low.
// Reset (rst, synchronous) empties queue and output, and sets rotation to none.
`timescale 1ns / 1ps

module lcd_draw_command_sequencer #(
  parameter int PANEL_WIDTH  = lds_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lds_pkg::PANEL_HEIGHT_DEF,
  parameter int QUEUE_DEPTH  = lds_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_x[8:0] start_y[17:9] line_length[26:18] rect_width[35:27]
  // rect_height[44:36] vertical[45] pixel_color[61:46], zero pad
  input  logic [63:0] s_tdata,
  // op[1:0]
  input  logic [1:0]  s_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  output logic        m_tvalid,
  input  logic        m_tready,
  // reg_index[7:0] reg_value[23:8] repeat_count[40:24], zero pad
  output logic [47:0] m_tdata,
  output logic        m_tlast
);

  lds_pkg::q_status_t q_status;
  lds_pkg::desc_t     push_data, head;
  logic               q_push, q_pop;

  lds_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  lds_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(push_data),
    .pop      (q_pop),
    .pop_data (head),
    .status   (q_status)
  );

  lds_back #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_status(q_status),
    .q_data  (head),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

`ifndef NO_ASSERTIONS
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue read while empty");
  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> m_tvalid && m_tlast)
    else $error("command retired without final write");
`endif

endmodule

@@ bench/tb_lcd_draw_command_sequencer.sv @@
// Testbench for lcd_draw_command_sequencer: random and directed draw commands, scoreboard check.
`timescale 1ns / 1ps

module tb_lcd_draw_command_sequencer;

  typedef struct {
    lds_pkg::op_t op;
    logic [8:0]   sx;
    logic [8:0]   sy;
    logic [8:0]   len;
    logic [8:0]   rw;
    logic [8:0]   rh;
    logic         vert;
    logic [15:0]  color;
  } draw_cmd_t;

  typedef struct packed {
    logic [7:0]  idx;
    logic [15:0] val;
    logic [16:0] rep;
    logic        last;
  } reg_write_t;

  class panel_write_checker;
    reg_write_t    pending_writes[$];
    lds_pkg::rot_t rotation;
    int            mismatches;

    function new();
      rotation   = lds_pkg::ROT_0;
      mismatches = 0;
    endfunction

    function void push(logic [7:0] idx, logic [15:0] val, logic [31:0] rep, logic last);
      reg_write_t w;
      w.idx  = idx;
      w.val  = val;
      w.rep  = (rep > 32'(lds_pkg::REPEAT_MAX)) ? lds_pkg::REPEAT_MAX : rep[16:0];
      w.last = last;
      pending_writes.push_back(w);
    endfunction

    function logic [15:0] entry_word(logic vert);
      logic [15:0] m;
      case (rotation)
        lds_pkg::ROT_90:
          m = vert ? lds_pkg::EM_INCV : (lds_pkg::EM_VERT | lds_pkg::EM_INCV);
        lds_pkg::ROT_180:
          m = vert ? lds_pkg::EM_VERT : 16'h0000;
        lds_pkg::ROT_270:
          m = vert ? lds_pkg::EM_INCH : (lds_pkg::EM_VERT | lds_pkg::EM_INCH);
        default:
          m = vert ? (lds_pkg::EM_VERT | lds_pkg::EM_INCH | lds_pkg::EM_INCV)
                   : (lds_pkg::EM_INCH | lds_pkg::EM_INCV);
      endcase
      return m;
    endfunction

    function void to_panel(logic [15:0] x0, logic [15:0] y0,
                           output logic [15:0] px, output logic [15:0] py);
      logic [15:0] w1;
      logic [15:0] h1;
      w1 = 16'(lds_pkg::PANEL_WIDTH_DEF - 1);
      h1 = 16'(lds_pkg::PANEL_HEIGHT_DEF - 1);
      case (rotation)
        lds_pkg::ROT_90:  begin px = w1 - y0; py = x0;      end
        lds_pkg::ROT_180: begin px = w1 - x0; py = h1 - y0; end
        lds_pkg::ROT_270: begin px = y0;      py = h1 - x0; end
        default:          begin px = x0;      py = y0;      end
      endcase
    endfunction

    function void note_command(draw_cmd_t c);
      logic [15:0] xa, ya, xb, yb, fx, fy, xmin, xmax, ymin, ymax;
      to_panel(16'(c.sx), 16'(c.sy), xa, ya);
      case (c.op)
        lds_pkg::OP_PIXEL: begin
          push(lds_pkg::REG_GRAM_X, xa, 1, 1'b0);
          push(lds_pkg::REG_GRAM_Y, ya, 1, 1'b0);
          push(lds_pkg::REG_GRAM_DATA, c.color, 1, 1'b1);
        end
        lds_pkg::OP_LINE: begin
          push(lds_pkg::REG_ENTRY, entry_word(c.vert), 1, 1'b0);
          push(lds_pkg::REG_GRAM_X, xa, 1, 1'b0);
          push(lds_pkg::REG_GRAM_Y, ya, 1, 1'b0);
          push(lds_pkg::REG_GRAM_DATA, c.color, 32'(c.len), 1'b1);
        end
        lds_pkg::OP_RECT: begin
          // far corner wraps at 16 bits when a size and its start are both zero
          fx = 16'(c.sx) + 16'(c.rw) - 16'd1;
          fy = 16'(c.sy) + 16'(c.rh) - 16'd1;
          to_panel(fx, fy, xb, yb);
          xmin = (xa > xb) ? xb : xa;
          xmax = (xa > xb) ? xa : xb;
          ymin = (ya > yb) ? yb : ya;
          ymax = (ya > yb) ? ya : yb;
          push(lds_pkg::REG_ENTRY, entry_word(1'b0), 1, 1'b0);
          push(lds_pkg::REG_WIN_X0, xmin, 1, 1'b0);
          push(lds_pkg::REG_WIN_X1, xmax, 1, 1'b0);
          push(lds_pkg::REG_WIN_Y0, ymin, 1, 1'b0);
          push(lds_pkg::REG_WIN_Y1, ymax, 1, 1'b0);
          push(lds_pkg::REG_GRAM_X, xmin, 1, 1'b0);
          push(lds_pkg::REG_GRAM_Y, ymin, 1, 1'b0);
          push(lds_pkg::REG_GRAM_DATA, c.color, 32'(c.rw) * 32'(c.rh), 1'b0);
          push(lds_pkg::REG_WIN_X0, 16'd0, 1, 1'b0);
          push(lds_pkg::REG_WIN_X1, 16'(lds_pkg::PANEL_WIDTH_DEF - 1), 1, 1'b0);
          push(lds_pkg::REG_WIN_Y0, 16'd0, 1, 1'b0);
          push(lds_pkg::REG_WIN_Y1, 16'(lds_pkg::PANEL_HEIGHT_DEF - 1), 1, 1'b1);
        end
        default: begin
          push(lds_pkg::REG_ENTRY, entry_word(1'b0), 1, 1'b0);
          push(lds_pkg::REG_GRAM_X, 16'd0, 1, 1'b0);
          push(lds_pkg::REG_GRAM_Y, 16'd0, 1, 1'b0);
          push(lds_pkg::REG_GRAM_DATA, c.color,
               32'(lds_pkg::PANEL_WIDTH_DEF * lds_pkg::PANEL_HEIGHT_DEF), 1'b1);
        end
      endcase
    endfunction

    function void check_write(reg_write_t got);
      reg_write_t exp;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected write: idx %02h val %04h rep %0d last %0b",
                   got.idx, got.val, got.rep, got.last);
        return;
      end
      exp = pending_writes.pop_front();
      if (got.idx !== exp.idx || got.val !== exp.val || got.rep !== exp.rep ||
          got.last !== exp.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %02h %04h %0d %0b, got %02h %04h %0d %0b",
                   exp.idx, exp.val, exp.rep, exp.last,
                   got.idx, got.val, got.rep, got.last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_data = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tlast;

  panel_write_checker sb;
  int   rx_mode = 0;
  logic hold_toggle = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   rx_cycle = 0;

  lcd_draw_command_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  // receiver: checks each write transaction and stalls on its own pattern
  always @(posedge clk) begin
    reg_write_t w;
    if (!rst && m_tvalid && m_tready) begin
      w.idx  = m_tdata[7:0];
      w.val  = m_tdata[23:8];
      w.rep  = m_tdata[40:24];
      w.last = m_tlast;
      sb.check_write(w);
    end
    rx_cycle <= rx_cycle + 1;
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= 300;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      case (rx_mode)
        1:       m_tready <= ($urandom_range(0, 1) == 1);
        2:       m_tready <= ((rx_cycle % 7) < 4);
        3:       m_tready <= ($urandom_range(0, 4) != 0);
        default: m_tready <= 1'b1;
      endcase
    end
  end

  task automatic send_cmd(draw_cmd_t c);
    s_tvalid <= 1'b1;
    s_tuser  <= c.op;
    s_tdata  <= {2'b00, c.color, c.vert, c.rh, c.rw, c.len, c.sy, c.sx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_command(c);
  endtask

  task automatic wait_drained();
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_rotation(lds_pkg::rot_t r);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.rotation = r;
  endtask

  function automatic draw_cmd_t make_cmd(lds_pkg::op_t op, int sx, int sy, int len,
                                         int rw, int rh, bit vert, int color);
    draw_cmd_t c;
    c.op    = op;
    c.sx    = 9'(sx);
    c.sy    = 9'(sy);
    c.len   = 9'(len);
    c.rw    = 9'(rw);
    c.rh    = 9'(rh);
    c.vert  = vert;
    c.color = 16'(color);
    return c;
  endfunction

  function automatic draw_cmd_t rand_cmd();
    draw_cmd_t c;
    bit wild;
    wild    = ($urandom_range(0, 99) < 20);
    c.op    = lds_pkg::op_t'($urandom_range(0, 3));
    c.sx    = wild ? 9'($urandom) : 9'($urandom_range(0, 319));
    c.sy    = wild ? 9'($urandom) : 9'($urandom_range(0, 319));
    c.len   = wild ? 9'($urandom) : 9'($urandom_range(0, 320));
    c.rw    = wild ? 9'($urandom) : 9'($urandom_range(1, 320));
    c.rh    = wild ? 9'($urandom) : 9'($urandom_range(1, 320));
    c.vert  = 1'($urandom);
    c.color = 16'($urandom);
    return c;
  endfunction

  task automatic run_traffic(int count, int max_gap);
    int burst;
    int gap;
    burst = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      send_cmd(rand_cmd());
      burst--;
      if (burst == 0 && i < count - 1) begin
        burst = $urandom_range(1, 12);
        gap   = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    draw_cmd_t     directed[$];
    lds_pkg::rot_t phase_rot[8];
    int            phase_rx[8];
    int            phase_gap[8];

    sb = new();
    phase_rot = '{lds_pkg::ROT_0, lds_pkg::ROT_270, lds_pkg::ROT_90, lds_pkg::ROT_180,
                  lds_pkg::ROT_0, lds_pkg::ROT_180, lds_pkg::ROT_270, lds_pkg::ROT_90};
    phase_rx  = '{0, 1, 2, 3, 1, 0, 2, 3};
    phase_gap = '{6, 0, 4, 8, 3, 5, 0, 2};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // field extremes, every op, zero sizes, wrap and repeat saturation
    directed.push_back(make_cmd(lds_pkg::OP_PIXEL, 0, 0, 0, 1, 1, 0, 16'h0000));
    directed.push_back(make_cmd(lds_pkg::OP_PIXEL, 319, 319, 0, 1, 1, 0, 16'hFFFF));
    directed.push_back(make_cmd(lds_pkg::OP_PIXEL, 511, 511, 511, 511, 511, 1, 16'hA5A5));
    directed.push_back(make_cmd(lds_pkg::OP_LINE, 10, 20, 0, 1, 1, 0, 16'h1234));
    directed.push_back(make_cmd(lds_pkg::OP_LINE, 0, 0, 511, 0, 0, 1, 16'h5A5A));
    directed.push_back(make_cmd(lds_pkg::OP_LINE, 0, 319, 320, 1, 1, 0, 16'h8001));
    directed.push_back(make_cmd(lds_pkg::OP_LINE, 319, 0, 1, 1, 1, 1, 16'h7FFE));
    directed.push_back(make_cmd(lds_pkg::OP_RECT, 0, 0, 0, 1, 1, 0, 16'h00FF));
    directed.push_back(make_cmd(lds_pkg::OP_RECT, 0, 0, 0, 320, 320, 0, 16'hFF00));
    directed.push_back(make_cmd(lds_pkg::OP_RECT, 511, 511, 0, 511, 511, 1, 16'hC3C3));
    directed.push_back(make_cmd(lds_pkg::OP_RECT, 5, 6, 0, 0, 5, 0, 16'h3C3C));
    directed.push_back(make_cmd(lds_pkg::OP_RECT, 0, 0, 0, 7, 0, 0, 16'h0F0F));
    directed.push_back(make_cmd(lds_pkg::OP_RECT, 239, 319, 0, 2, 2, 0, 16'hF0F0));
    directed.push_back(make_cmd(lds_pkg::OP_FILL, 0, 0, 0, 0, 0, 0, 16'h1234));
    directed.push_back(make_cmd(lds_pkg::OP_FILL, 511, 511, 511, 511, 511, 1, 16'hFFFF));

    foreach (phase_rot[p]) begin
      write_rotation(phase_rot[p]);
      rx_mode = phase_rx[p];
      if (p == 0) begin
        foreach (directed[i]) send_cmd(directed[i]);
        s_tvalid <= 1'b0;
        wait_drained();
      end
      if (p == 2 || p == 5)
        hold_toggle <= ~hold_toggle;
      run_traffic(60, phase_gap[p]);
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending_writes.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/lds_pkg.sv
rtl/lds_front.sv
rtl/lds_queue.sv
rtl/lds_back.sv
rtl/lcd_draw_command_sequencer.sv
bench/tb_lcd_draw_command_sequencer.sv
